/* rtl/core/bpa_pkg.sv */
package bpa_pkg;

	localparam int MinOrder  = 12;
	localparam int MaxOrder  = 20;
	localparam int PageCount = 1024;
	localparam int PageW     = 10;
	localparam int LinkW     = 11;
	localparam int OrdW      = 6;
	localparam int ListDepth = 21;
	localparam int ListW     = 5;
	localparam int ReqW      = 32;
	localparam int OffW      = 22;
	localparam int BlkW      = 21;
	localparam int CfgW      = 11;

	localparam logic [LinkW-1:0] NilPage        = LinkW'(PageCount);
	localparam logic [CfgW-1:0]  HeapPagesReset = CfgW'(1024);
	localparam logic [OrdW-1:0]  MinOrd         = OrdW'(MinOrder);
	localparam logic [OrdW-1:0]  MaxOrd         = OrdW'(MaxOrder);

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REBUILD = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO_SIZE = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_NO_BLOCK  = 3'd3,
		ST_OUTSIDE   = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		DP_NOP, DP_ALLOC_INIT, DP_FREE_INIT, DP_RB_INIT, DP_SCAN_STEP, DP_RB_TOP,
		DP_CLEAR, DP_CARVE_START, DP_CARVE_FIT, DP_CARVE_SHRINK, DP_PUSH_A, DP_PUSH_B,
		DP_PUSH_B_ADV, DP_SEARCH_INIT, DP_CUR_INC, DP_CUR_DEC, DP_TAKE, DP_UNLINK,
		DP_ALLOC_FIN, DP_FREE_ORD, DP_BUDDY, DP_MERGE
	} dp_op_t;

	// which page a push or unlink works on
	typedef enum logic [1:0] {TS_PG, TS_SPLIT, TS_BUDDY} tgt_sel_t;
	typedef enum logic [1:0] {RA_PAGE, RA_HEAD, RA_BUDDY} ra_sel_t;
	typedef enum logic [2:0] {RO_ZERO, RO_ORD, RO_CUR, RO_ATTR, RO_TOP} ro_sel_t;

	typedef struct packed {
		logic            free;
		logic [OrdW-1:0] ord;
	} attr_t;

	typedef struct packed {
		dp_op_t   op;
		tgt_sel_t tsel;
		ra_sel_t  ra;
		logic     res_we;
		status_t  res_status;
		ro_sel_t  res_ord;
		logic     res_off;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic zero_req;
		logic blk_lt;
		logic ord_le_top;
		logic ord_lt_max;
		logic pg_lt_n;
		logic shrink;
		logic head_nil;
		logic cur_le_top;
		logic cur_gt_ord;
		logic cur_lt_top;
		logic pg_ge_built;
		logic attr_free;
		logic buddy_out;
		logic buddy_match;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_BOOT, S_IDLE, S_A_SCAN, S_A_SEARCH, S_A_UNLINK, S_A_SPLIT, S_A_PUSHA, S_A_PUSHB,
		S_F_CHK, S_F_ATTR, S_F_LOOP, S_F_BCHK, S_F_MERGE, S_F_PUSHB,
		S_R_TOP, S_R_CLEAR, S_R_CARVE, S_R_SHRINK, S_R_PUSHB, S_DONE
	} state_t;

endpackage

/* rtl/core/bpa_ctrl.sv */
module bpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	output logic              out_valid,
	input  logic              out_ready,
	input  bpa_pkg::dp_stat_t stat,
	output bpa_pkg::dp_cmd_t  cmd
);
	import bpa_pkg::*;

	state_t state_q, state_d;
	logic   boot_q;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_BOOT;
			boot_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_R_CARVE && !stat.pg_lt_n)
				boot_q <= 1'b0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_BOOT: state_d = S_R_TOP;
			S_IDLE: begin
				if (in_valid) begin
					unique case (op_t'(op))
						OP_ALLOC:   state_d = S_A_SCAN;
						OP_FREE:    state_d = S_F_CHK;
						OP_REBUILD: state_d = S_R_TOP;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_A_SCAN: begin
				if (stat.zero_req)
					state_d = S_DONE;
				else if (stat.blk_lt && stat.ord_le_top)
					state_d = S_A_SCAN;
				else if (!stat.ord_le_top)
					state_d = S_DONE;
				else
					state_d = S_A_SEARCH;
			end
			S_A_SEARCH: begin
				if (!stat.cur_le_top)
					state_d = S_DONE;
				else if (!stat.head_nil)
					state_d = S_A_UNLINK;
			end
			S_A_UNLINK: state_d = S_A_SPLIT;
			S_A_SPLIT:  state_d = stat.cur_gt_ord ? S_A_PUSHA : S_DONE;
			S_A_PUSHA:  state_d = S_A_PUSHB;
			S_A_PUSHB:  state_d = S_A_SPLIT;
			S_F_CHK:    state_d = stat.pg_ge_built ? S_DONE : S_F_ATTR;
			S_F_ATTR:   state_d = stat.attr_free ? S_DONE : S_F_LOOP;
			S_F_LOOP:   state_d = (stat.cur_lt_top && !stat.buddy_out) ? S_F_BCHK : S_F_PUSHB;
			S_F_BCHK:   state_d = stat.buddy_match ? S_F_MERGE : S_F_PUSHB;
			S_F_MERGE:  state_d = S_F_LOOP;
			S_F_PUSHB:  state_d = S_DONE;
			S_R_TOP:    state_d = (stat.blk_lt && stat.ord_lt_max) ? S_R_TOP : S_R_CLEAR;
			S_R_CLEAR:  state_d = stat.pg_lt_n ? S_R_CLEAR : S_R_CARVE;
			S_R_CARVE: begin
				if (stat.pg_lt_n)
					state_d = S_R_SHRINK;
				else
					state_d = boot_q ? S_IDLE : S_DONE;
			end
			S_R_SHRINK: state_d = stat.shrink ? S_R_SHRINK : S_R_PUSHB;
			S_R_PUSHB:  state_d = S_R_CARVE;
			S_DONE:     state_d = (!out_valid_q || out_ready) ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = DP_NOP;
		cmd.tsel      = TS_PG;
		cmd.ra        = RA_PAGE;
		cmd.res_status = ST_OK;
		cmd.res_ord   = RO_ZERO;
		in_ready      = (state_q == S_IDLE);
		out_valid     = out_valid_q;
		unique case (state_q)
			S_BOOT: cmd.op = DP_RB_INIT;
			S_IDLE: begin
				if (in_valid) begin
					unique case (op_t'(op))
						OP_ALLOC:   cmd.op = DP_ALLOC_INIT;
						OP_FREE:    cmd.op = DP_FREE_INIT;
						OP_REBUILD: cmd.op = DP_RB_INIT;
						default:    cmd.res_we = 1'b1;
					endcase
				end
			end
			S_A_SCAN: begin
				if (stat.zero_req) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_ZERO_SIZE;
				end else if (stat.blk_lt && stat.ord_le_top) begin
					cmd.op = DP_SCAN_STEP;
				end else if (!stat.ord_le_top) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_TOO_LARGE;
				end else begin
					cmd.op = DP_SEARCH_INIT;
				end
			end
			S_A_SEARCH: begin
				cmd.ra = RA_HEAD;
				if (!stat.cur_le_top) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_NO_BLOCK;
				end else if (stat.head_nil) begin
					cmd.op = DP_CUR_INC;
				end else begin
					cmd.op = DP_TAKE;
				end
			end
			S_A_UNLINK: cmd.op = DP_UNLINK;
			S_A_SPLIT: begin
				if (stat.cur_gt_ord) begin
					cmd.op = DP_CUR_DEC;
				end else begin
					cmd.op      = DP_ALLOC_FIN;
					cmd.res_we  = 1'b1;
					cmd.res_ord = RO_ORD;
					cmd.res_off = 1'b1;
				end
			end
			S_A_PUSHA: begin
				cmd.op   = DP_PUSH_A;
				cmd.tsel = TS_SPLIT;
			end
			S_A_PUSHB: cmd.op = DP_PUSH_B;
			S_F_CHK: begin
				if (stat.pg_ge_built) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_OUTSIDE;
				end
			end
			S_F_ATTR: begin
				if (stat.attr_free) begin
					cmd.res_we  = 1'b1;
					cmd.res_ord = RO_ATTR;
				end else begin
					cmd.op = DP_FREE_ORD;
				end
			end
			S_F_LOOP: begin
				if (stat.cur_lt_top && !stat.buddy_out) begin
					cmd.op = DP_BUDDY;
					cmd.ra = RA_BUDDY;
				end else begin
					cmd.op = DP_PUSH_A;
				end
			end
			S_F_BCHK: begin
				if (stat.buddy_match) begin
					cmd.op   = DP_UNLINK;
					cmd.tsel = TS_BUDDY;
				end else begin
					cmd.op = DP_PUSH_A;
				end
			end
			S_F_MERGE: cmd.op = DP_MERGE;
			S_F_PUSHB: begin
				cmd.op      = DP_PUSH_B;
				cmd.res_we  = 1'b1;
				cmd.res_ord = RO_CUR;
			end
			S_R_TOP: cmd.op = (stat.blk_lt && stat.ord_lt_max) ? DP_SCAN_STEP : DP_RB_TOP;
			S_R_CLEAR: cmd.op = stat.pg_lt_n ? DP_CLEAR : DP_CARVE_START;
			S_R_CARVE: begin
				if (stat.pg_lt_n) begin
					cmd.op = DP_CARVE_FIT;
				end else if (!boot_q) begin
					cmd.res_we  = 1'b1;
					cmd.res_ord = RO_TOP;
				end
			end
			S_R_SHRINK: cmd.op = stat.shrink ? DP_CARVE_SHRINK : DP_PUSH_A;
			S_R_PUSHB:  cmd.op = DP_PUSH_B_ADV;
			S_DONE:     cmd.out_load = !out_valid_q || out_ready;
			default:    cmd.op = DP_NOP;
		endcase
	end

endmodule

/* rtl/core/bpa_dp.sv */
module bpa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::CfgW-1:0]      cfg_data,
	input  logic [bpa_pkg::ReqW-1:0]      request_bytes,
	input  logic [bpa_pkg::OffW-1:0]      free_offset,
	input  bpa_pkg::dp_cmd_t              cmd,
	output bpa_pkg::dp_stat_t             stat,
	output logic [2:0]                    status,
	output logic [bpa_pkg::OffW-1:0]      block_offset,
	output logic [bpa_pkg::OrdW-1:0]      block_order
);
	import bpa_pkg::*;

	logic [CfgW-1:0]  heap_pages_q;
	logic [OrdW-1:0]  top_q, ord_q, cur_q;
	logic [LinkW-1:0] built_q, n_q, pg_q, buddy_q, h_q, psave_q, span_q;
	logic [ReqW-1:0]  tgt_q;
	logic [BlkW-1:0]  blk_q;
	logic [LinkW-1:0] head_q [ListDepth];

	logic [LinkW-1:0] next_mem [PageCount];
	logic [LinkW-1:0] prev_mem [PageCount];
	attr_t            attr_mem [PageCount];
	logic [LinkW-1:0] nx_rd_q, pv_rd_q;
	attr_t            attr_rd_q;

	status_t          res_status_q;
	logic [OffW-1:0]  res_off_q;
	logic [OrdW-1:0]  res_order_q;
	logic [2:0]       out_status_q;
	logic [OffW-1:0]  out_off_q;
	logic [OrdW-1:0]  out_order_q;

	logic [LinkW-1:0] head_rd, span_cur, buddy_c, push_pg, unl_pg, n_sel, rd_addr;
	logic [OrdW-1:0]  carve_ord, free_ord, res_ord_d;
	logic             next_we, prev_we, attr_we;
	logic [LinkW-1:0] next_wa, next_wd, prev_wa, prev_wd, attr_wa;
	attr_t            attr_wd;

	assign head_rd   = head_q[cur_q[ListW-1:0]];
	assign span_cur  = LinkW'(1) << (cur_q - MinOrd);
	assign buddy_c   = pg_q ^ span_cur;
	assign push_pg   = (cmd.tsel == TS_SPLIT) ? pg_q + span_cur : pg_q;
	assign unl_pg    = (cmd.tsel == TS_BUDDY) ? buddy_q : pg_q;
	assign n_sel     = (heap_pages_q > NilPage) ? NilPage : heap_pages_q;
	assign carve_ord = (top_q < MinOrd) ? MinOrd : top_q;
	assign free_ord  = (attr_rd_q.ord < MinOrd) ? MinOrd : attr_rd_q.ord;

	always_comb begin
		unique case (cmd.ra)
			RA_HEAD:  rd_addr = head_rd;
			RA_BUDDY: rd_addr = buddy_c;
			default:  rd_addr = pg_q;
		endcase
	end

	always_comb begin
		stat.zero_req    = (tgt_q == '0);
		stat.blk_lt      = ReqW'(blk_q) < tgt_q;
		stat.ord_le_top  = ord_q <= top_q;
		stat.ord_lt_max  = ord_q < MaxOrd;
		stat.pg_lt_n     = pg_q < n_q;
		stat.shrink      = (cur_q > MinOrd) &&
			((span_q > n_q - pg_q) || ((pg_q & (span_q - LinkW'(1))) != '0));
		stat.head_nil    = head_rd == NilPage;
		stat.cur_le_top  = cur_q <= top_q;
		stat.cur_gt_ord  = cur_q > ord_q;
		stat.cur_lt_top  = cur_q < top_q;
		stat.pg_ge_built = pg_q >= built_q;
		stat.attr_free   = attr_rd_q.free;
		stat.buddy_out   = buddy_c >= built_q;
		stat.buddy_match = attr_rd_q.free && (attr_rd_q.ord == cur_q);
	end

	// memory write ports, at most one write per memory each cycle
	always_comb begin
		next_we = 1'b0;
		next_wa = pg_q;
		next_wd = head_rd;
		prev_we = 1'b0;
		prev_wa = pg_q;
		prev_wd = NilPage;
		attr_we = 1'b0;
		attr_wa = pg_q;
		attr_wd = '0;
		unique case (cmd.op)
			DP_PUSH_A: begin
				next_we = 1'b1;
				next_wa = push_pg;
				next_wd = head_rd;
				prev_we = 1'b1;
				prev_wa = push_pg;
				prev_wd = NilPage;
				attr_we = 1'b1;
				attr_wa = push_pg;
				attr_wd = '{free: 1'b1, ord: cur_q};
			end
			DP_PUSH_B, DP_PUSH_B_ADV: begin
				prev_we = h_q < NilPage;
				prev_wa = h_q;
				prev_wd = psave_q;
			end
			DP_UNLINK: begin
				next_we = pv_rd_q < NilPage;
				next_wa = pv_rd_q;
				next_wd = nx_rd_q;
				prev_we = nx_rd_q < NilPage;
				prev_wa = nx_rd_q;
				prev_wd = pv_rd_q;
				attr_we = 1'b1;
				attr_wa = unl_pg;
				attr_wd = '{free: 1'b0, ord: cur_q};
			end
			DP_CLEAR: begin
				attr_we = 1'b1;
				attr_wa = pg_q;
				attr_wd = '0;
			end
			DP_ALLOC_FIN: begin
				attr_we = 1'b1;
				attr_wa = pg_q;
				attr_wd = '{free: 1'b0, ord: ord_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (next_we)
			next_mem[next_wa[PageW-1:0]] <= next_wd;
		nx_rd_q <= next_mem[rd_addr[PageW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (prev_we)
			prev_mem[prev_wa[PageW-1:0]] <= prev_wd;
		pv_rd_q <= prev_mem[rd_addr[PageW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (attr_we)
			attr_mem[attr_wa[PageW-1:0]] <= attr_wd;
		attr_rd_q <= attr_mem[rd_addr[PageW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			heap_pages_q <= HeapPagesReset;
		else if (cfg_we)
			heap_pages_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_ALLOC_INIT: begin
				tgt_q <= request_bytes;
				ord_q <= MinOrd;
				blk_q <= BlkW'(1) << MinOrder;
			end
			DP_FREE_INIT: pg_q <= LinkW'(free_offset[OffW-1:MinOrder]);
			DP_RB_INIT: begin
				n_q   <= n_sel;
				tgt_q <= ReqW'(n_sel) << MinOrder;
				ord_q <= MinOrd;
				blk_q <= BlkW'(1) << MinOrder;
				for (int i = 0; i < ListDepth; i++)
					head_q[i] <= NilPage;
			end
			DP_SCAN_STEP: begin
				ord_q <= ord_q + OrdW'(1);
				blk_q <= blk_q << 1;
			end
			DP_RB_TOP: begin
				top_q   <= ord_q - OrdW'(1);
				built_q <= n_q;
				pg_q    <= '0;
			end
			DP_CLEAR:       pg_q <= pg_q + LinkW'(1);
			DP_CARVE_START: pg_q <= '0;
			DP_CARVE_FIT: begin
				cur_q  <= carve_ord;
				span_q <= LinkW'(1) << (carve_ord - MinOrd);
			end
			DP_CARVE_SHRINK: begin
				cur_q  <= cur_q - OrdW'(1);
				span_q <= span_q >> 1;
			end
			DP_PUSH_A: begin
				head_q[cur_q[ListW-1:0]] <= push_pg;
				h_q     <= head_rd;
				psave_q <= push_pg;
			end
			DP_PUSH_B_ADV:  pg_q  <= pg_q + span_q;
			DP_SEARCH_INIT: cur_q <= ord_q;
			DP_CUR_INC:     cur_q <= cur_q + OrdW'(1);
			DP_CUR_DEC:     cur_q <= cur_q - OrdW'(1);
			DP_TAKE:        pg_q  <= head_rd;
			DP_UNLINK: begin
				if (pv_rd_q >= NilPage)
					head_q[cur_q[ListW-1:0]] <= nx_rd_q;
			end
			DP_FREE_ORD: cur_q   <= free_ord;
			DP_BUDDY:    buddy_q <= buddy_c;
			DP_MERGE: begin
				if (buddy_q < pg_q)
					pg_q <= buddy_q;
				cur_q <= cur_q + OrdW'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		case (cmd.res_ord)
			RO_ORD:  res_ord_d = ord_q;
			RO_CUR:  res_ord_d = cur_q;
			RO_ATTR: res_ord_d = attr_rd_q.ord;
			RO_TOP:  res_ord_d = top_q;
			default: res_ord_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_we) begin
			res_status_q <= cmd.res_status;
			res_off_q    <= cmd.res_off ? {pg_q[PageW-1:0], {MinOrder{1'b0}}} : '0;
			res_order_q  <= res_ord_d;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_off_q    <= res_off_q;
			out_order_q  <= res_order_q;
		end
	end

	assign status       = out_status_q;
	assign block_offset = out_off_q;
	assign block_order  = out_order_q;

endmodule

/* rtl/core/buddy_page_allocator_core.sv */
// Allocate runs an order scan, a list search and a split for each order by which
// the found block exceeds the request; free merges with each matching free buddy in
// turn; rebuild clears every page and then carves the heap into aligned blocks, all
// stepped by the sequencer through the link and attribute memories.
// One request in flight; a finished result waits in the output register meanwhile.
// Reset: asynchronous; the heap is rebuilt from 1024 pages with in_ready low.
module buddy_page_allocator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [bpa_pkg::ReqW-1:0]     request_bytes,
	input  logic [bpa_pkg::OffW-1:0]     free_offset,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [bpa_pkg::OffW-1:0]     block_offset,
	output logic [bpa_pkg::OrdW-1:0]     block_order,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bpa_pkg::CfgW-1:0]     heap_pages
);
	import bpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid),
		.cfg_data      (heap_pages),
		.request_bytes (request_bytes),
		.free_offset   (free_offset),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.block_offset  (block_offset),
		.block_order   (block_order)
	);

endmodule
